>>> rtl/core/dssr_pkg.sv
package dssr_pkg;

    localparam int MAX_ELEMENTS = 1023;
    localparam int ELEMENT_BITS = 32;

    // slots 0..capacity, capacity never above MAX_ELEMENTS
    localparam int DEPTH = MAX_ELEMENTS + 1;
    localparam int PTR_W = $clog2(DEPTH);

    // fixed field widths
    localparam int CAP_W  = 10;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CMP_W  = (PTR_W > CAP_W) ? PTR_W : CAP_W;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic SEL_FIRST  = 1'b0;
    localparam logic SEL_SECOND = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_PUSH_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_POP_EMPTY = 2'd2;

    // per-transaction decision from the pointer control
    typedef struct packed {
        logic              mem_we;
        logic              mem_re;
        logic [PTR_W-1:0]  mem_addr;
        logic [STAT_W-1:0] status;
        logic              first_empty;
        logic              second_empty;
        logic              store_full;
    } step_t;

endpackage

>>> rtl/core/dssr_ctrl.sv
module dssr_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [dssr_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                       accept,
    input  logic                       opcode,
    input  logic                       stack_select,
    output dssr_pkg::step_t            step
);
    import dssr_pkg::*;

    logic [PTR_W-1:0] capacity_reg;
    logic [PTR_W-1:0] capacity_next;
    logic [PTR_W-1:0] first_free_reg;
    logic [PTR_W-1:0] first_free_next;
    logic [PTR_W-1:0] second_free_reg;
    logic [PTR_W-1:0] second_free_next;
    logic [CMP_W-1:0] cfg_wide;
    logic [PTR_W-1:0] cap_clamped;

    function automatic logic [PTR_W-1:0] wrap_down(input logic [PTR_W-1:0] p,
                                                   input logic [PTR_W-1:0] cap);
        logic [PTR_W-1:0] r;
        if (p == '0)
        begin
            r = cap;
        end
        else
        begin
            r = p - PTR_W'(1);
        end
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] wrap_up(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] cap);
        logic [PTR_W-1:0] r;
        if (p >= cap)
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // zero reads as one, values above the store size saturate
    always_comb
    begin
        cfg_wide = CMP_W'(cfg_wr_data);
        if (cfg_wide == '0)
        begin
            cap_clamped = PTR_W'(1);
        end
        else if (cfg_wide > CMP_W'(MAX_ELEMENTS))
        begin
            cap_clamped = PTR_W'(MAX_ELEMENTS);
        end
        else
        begin
            cap_clamped = cfg_wide[PTR_W-1:0];
        end
    end

    always_comb
    begin
        capacity_next    = capacity_reg;
        first_free_next  = first_free_reg;
        second_free_next = second_free_reg;
        step.mem_we      = 1'b0;
        step.mem_re      = 1'b0;
        step.mem_addr    = first_free_reg;
        step.status      = ST_DONE;

        if (cfg_wr_en)
        begin
            capacity_next    = cap_clamped;
            first_free_next  = cap_clamped - PTR_W'(1);
            second_free_next = cap_clamped;
        end
        else if (accept)
        begin
            if (opcode == OP_PUSH)
            begin
                if (first_free_reg == second_free_reg)
                begin
                    step.status = ST_PUSH_FULL;
                end
                else if (stack_select == SEL_FIRST)
                begin
                    step.mem_we     = 1'b1;
                    step.mem_addr   = first_free_reg;
                    first_free_next = wrap_down(first_free_reg, capacity_reg);
                end
                else
                begin
                    step.mem_we      = 1'b1;
                    step.mem_addr    = second_free_reg;
                    second_free_next = wrap_up(second_free_reg, capacity_reg);
                end
            end
            else if (stack_select == SEL_FIRST)
            begin
                if (first_free_reg == capacity_reg - PTR_W'(1))
                begin
                    step.status = ST_POP_EMPTY;
                end
                else
                begin
                    first_free_next = wrap_up(first_free_reg, capacity_reg);
                    step.mem_re     = 1'b1;
                    step.mem_addr   = first_free_next;
                end
            end
            else
            begin
                if (second_free_reg == capacity_reg)
                begin
                    step.status = ST_POP_EMPTY;
                end
                else
                begin
                    second_free_next = wrap_down(second_free_reg, capacity_reg);
                    step.mem_re      = 1'b1;
                    step.mem_addr    = second_free_next;
                end
            end
        end

        step.first_empty  = (first_free_next == capacity_reg - PTR_W'(1));
        step.second_empty = (second_free_next == capacity_reg);
        step.store_full   = (first_free_next == second_free_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= PTR_W'(MAX_ELEMENTS);
            first_free_reg  <= PTR_W'(MAX_ELEMENTS - 1);
            second_free_reg <= PTR_W'(MAX_ELEMENTS);
        end
        else
        begin
            capacity_reg    <= capacity_next;
            first_free_reg  <= first_free_next;
            second_free_reg <= second_free_next;
        end
    end

    a_first_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        first_free_reg <= capacity_reg)
        else $error("first free pointer beyond ring");

    a_second_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        second_free_reg <= capacity_reg)
        else $error("second free pointer beyond ring");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(step.mem_we && step.mem_re))
        else $error("read and write requested together");

endmodule

>>> rtl/core/dual_stack_shared_ring_unit.sv
// result path: a taken transaction goes through the registered memory read (stage 1),
// then the output register
// throughput: one transaction per cycle while the output is not stalled; the slot memory has a single port and
// each push or pop uses it once, pointers update in the same cycle
// reset: capacity 1023, both stacks empty, memory contents undefined (no clear
// pass); a capacity write also empties both stacks and keeps the data
module dual_stack_shared_ring_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    // capacity register
    input  logic                        cfg_wr_en,
    input  logic [dssr_pkg::CAP_W-1:0]  cfg_wr_data,
    // request stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,  // push_value[31:0]
    input  logic [1:0]                  s_axis_tuser,  // opcode[0], stack_select[1]
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // pop_value[31:0], first_empty[32], second_empty[33], store_full[34], zero pad
    output logic [39:0]                 m_axis_tdata,
    output logic [1:0]                  m_axis_tuser   // status[1:0]
);
    import dssr_pkg::*;

    step_t                   step;
    logic                    accept;
    logic                    out_free;
    logic                    s1_move;

    // slot memory, one port, registered read
    logic [ELEMENT_BITS-1:0] slot_mem [DEPTH];
    logic [ELEMENT_BITS-1:0] rd_data_reg;
    logic [ELEMENT_BITS-1:0] wr_data;
    logic [ELEMENT_BITS+DATA_W-1:0] wr_wide;
    logic [ELEMENT_BITS+DATA_W-1:0] rd_wide;

    // stage 1: transaction taken, memory read in flight
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s1_pop_ok_reg;
    logic [STAT_W-1:0]       s1_status_reg;
    logic                    s1_first_empty_reg;
    logic                    s1_second_empty_reg;
    logic                    s1_full_reg;
    logic [DATA_W-1:0]       s1_pop_value;

    // output register
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic [39:0]             m_tdata_reg;
    logic [1:0]              m_tuser_reg;

    // stage 1 can always drain into a free output register, so the
    // request side only stalls when both are full and the sink holds off
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s1_move       = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    dssr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .accept       (accept),
        .opcode       (s_axis_tuser[0]),
        .stack_select (s_axis_tuser[1]),
        .step         (step)
    );

    // element width may differ from the 32-bit port
    assign wr_wide      = {{ELEMENT_BITS{1'b0}}, s_axis_tdata};
    assign wr_data      = wr_wide[ELEMENT_BITS-1:0];
    assign rd_wide      = {{DATA_W{1'b0}}, rd_data_reg};
    assign s1_pop_value = s1_pop_ok_reg ? rd_wide[DATA_W-1:0] : '0;

    // a pop is taken in a later cycle than any push it depends on, and
    // one transaction never reads and writes at once: no forwarding needed
    always_ff @(posedge clk)
    begin
        if (step.mem_we)
        begin
            slot_mem[step.mem_addr] <= wr_data;
        end
        if (step.mem_re)
        begin
            rd_data_reg <= slot_mem[step.mem_addr];
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_move)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pop_ok_reg       <= step.mem_re;
            s1_status_reg       <= step.status;
            s1_first_empty_reg  <= step.first_empty;
            s1_second_empty_reg <= step.second_empty;
            s1_full_reg         <= step.store_full;
        end
        if (s1_move)
        begin
            m_tdata_reg <= {5'b0, s1_full_reg, s1_second_empty_reg,
                            s1_first_empty_reg, s1_pop_value};
            m_tuser_reg <= s1_status_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && m_valid_reg))
        else $error("request side stalled with room in the pipe");

    a_refused_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_tuser_reg == ST_POP_EMPTY) |-> (m_tdata_reg[31:0] == '0))
        else $error("refused pop carries data");

    a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_tdata_reg[32] && m_tdata_reg[33]) |-> !m_tdata_reg[34])
        else $error("both stacks empty yet store full");

    a_pop_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step.mem_re) |=> (s1_valid_reg && s1_pop_ok_reg))
        else $error("pop read not tracked in stage 1");

endmodule

>>> bench/ring_monitor.sv
`timescale 1ns / 1ps

module ring_monitor (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [dssr_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,
    input  logic [1:0]                 s_axis_tuser,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [39:0]                m_axis_tdata,
    input  logic [1:0]                 m_axis_tuser,
    output int                         mismatches,
    output int                         outstanding,
    output int                         results_checked,
    output int                         full_refusals,
    output int                         empty_refusals
);
    import dssr_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] pop_value;
        logic              first_empty;
        logic              second_empty;
        logic              store_full;
    } ring_result_t;

    ring_result_t      expected_results[$];
    ring_result_t      got;
    ring_result_t      want;
    logic [DATA_W-1:0] slot_copy [0:DEPTH-1];
    logic [CAP_W-1:0]  ring_capacity;
    logic [CAP_W-1:0]  down_free;   // next free slot of the downward stack
    logic [CAP_W-1:0]  up_free;     // next free slot of the upward stack

    function automatic logic [CAP_W-1:0] ring_dec(input logic [CAP_W-1:0] p);
        return (p == '0) ? ring_capacity : p - 1'b1;
    endfunction

    function automatic logic [CAP_W-1:0] ring_inc(input logic [CAP_W-1:0] p);
        return (p >= ring_capacity) ? '0 : p + 1'b1;
    endfunction

    function automatic ring_result_t apply_request(input logic op, input logic sel,
                                                   input logic [DATA_W-1:0] value);
        ring_result_t r;
        r = '0;
        r.status = ST_DONE;
        if (op == OP_PUSH)
        begin
            if (down_free == up_free)
                r.status = ST_PUSH_FULL;
            else if (sel == SEL_FIRST)
            begin
                slot_copy[down_free] = value;
                down_free = ring_dec(down_free);
            end
            else
            begin
                slot_copy[up_free] = value;
                up_free = ring_inc(up_free);
            end
        end
        else if (sel == SEL_FIRST)
        begin
            if (down_free == ring_capacity - 1'b1)
                r.status = ST_POP_EMPTY;
            else
            begin
                down_free = ring_inc(down_free);
                r.pop_value = slot_copy[down_free];
            end
        end
        else
        begin
            if (up_free == ring_capacity)
                r.status = ST_POP_EMPTY;
            else
            begin
                up_free = ring_dec(up_free);
                r.pop_value = slot_copy[up_free];
            end
        end
        r.first_empty  = (down_free == ring_capacity - 1'b1);
        r.second_empty = (up_free == ring_capacity);
        r.store_full   = (down_free == up_free);
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t mismatch (%s): expected st %0d pop %h fe %b se %b full %b,",
                      " got st %0d pop %h fe %b se %b full %b"},
                     $realtime, what, want.status, want.pop_value, want.first_empty,
                     want.second_empty, want.store_full, got.status, got.pop_value,
                     got.first_empty, got.second_empty, got.store_full);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            ring_capacity   = CAP_W'(MAX_ELEMENTS);
            down_free       = CAP_W'(MAX_ELEMENTS - 1);
            up_free         = CAP_W'(MAX_ELEMENTS);
            mismatches      = 0;
            outstanding     = 0;
            results_checked = 0;
            full_refusals   = 0;
            empty_refusals  = 0;
        end
        else
        begin
            // a capacity write empties both stacks, zero counts as one
            if (cfg_wr_en)
            begin
                ring_capacity = (cfg_wr_data == '0) ? CAP_W'(1) : cfg_wr_data;
                down_free     = ring_capacity - 1'b1;
                up_free       = ring_capacity;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_request(s_axis_tuser[0], s_axis_tuser[1],
                                                         s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status       = m_axis_tuser;
                got.pop_value    = m_axis_tdata[31:0];
                got.first_empty  = m_axis_tdata[32];
                got.second_empty = m_axis_tdata[33];
                got.store_full   = m_axis_tdata[34];
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    want = 'x;
                    note_mismatch("no request waiting");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.status == ST_PUSH_FULL)
                        full_refusals++;
                    if (want.status == ST_POP_EMPTY)
                        empty_refusals++;
                    if (got.status !== want.status || got.pop_value !== want.pop_value ||
                        got.first_empty !== want.first_empty ||
                        got.second_empty !== want.second_empty ||
                        got.store_full !== want.store_full)
                        note_mismatch("field differs");
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dssr_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CAP_W-1:0]  cfg_wr_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata;   // push_value[31:0]
    logic [1:0]        s_axis_tuser;   // opcode[0], stack_select[1]
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [39:0]       m_axis_tdata;   // pop_value, first_empty, second_empty, store_full
    logic [1:0]        m_axis_tuser;   // status[1:0]

    // figures reported by the monitor
    int mismatches;
    int outstanding;
    int results_checked;
    int full_refusals;
    int empty_refusals;

    // stimulus bookkeeping
    int requests_sent;
    int capacity_writes;
    int rx_hold_cycles;   // set by the stimulus, consumed by the result side
    bit no_gaps;          // both sides run back to back while set

    dual_stack_shared_ring_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ring_monitor ring_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .full_refusals   (full_refusals),
        .empty_refusals  (empty_refusals)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("[dual_stack_shared_ring_unit] ERROR");
        $finish;
    end

    // result side: random stalls per transaction, plus one long hold-off on request
    initial
    begin : result_side
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            stall = no_gaps ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // one request transaction, preceded by a random gap unless running back to back
    task automatic send_request(input logic op, input logic sel, input logic [31:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= {sel, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    // stop offering and wait for every outstanding result, then the pipeline latency
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (3) @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        capacity_writes++;
    endtask

    // random mix on both stacks; push_pct steers toward full or toward empty
    task automatic random_phase(input int count, input int push_pct);
        logic        op;
        logic        sel;
        logic [31:0] value;
        for (int i = 0; i < count; i++)
        begin
            op  = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            sel = $urandom_range(0, 1) ? SEL_SECOND : SEL_FIRST;
            case ($urandom_range(0, 15))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7fff_ffff;
                2:       value = 32'h0000_0000;
                3:       value = 32'hffff_ffff;
                default: value = $urandom;
            endcase
            send_request(op, sel, value);
        end
    endtask

    initial
    begin : stimulus
        int cap;
        int push_pct;
        requests_sent   = 0;
        capacity_writes = 0;
        rx_hold_cycles  = 0;
        no_gaps         = 1'b0;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacity: pops on empty stacks, extreme values, upward stack wraps to slot 0
        send_request(OP_POP,  SEL_FIRST,  32'h0);
        send_request(OP_POP,  SEL_SECOND, 32'hdead_beef);
        send_request(OP_PUSH, SEL_FIRST,  32'h7fff_ffff);
        send_request(OP_PUSH, SEL_SECOND, 32'h8000_0000);
        send_request(OP_POP,  SEL_SECOND, 32'h0);
        send_request(OP_POP,  SEL_FIRST,  32'h0);
        send_request(OP_PUSH, SEL_FIRST,  32'h0000_0000);
        send_request(OP_PUSH, SEL_SECOND, 32'hffff_ffff);
        send_request(OP_POP,  SEL_FIRST,  32'h1234_5678);
        send_request(OP_POP,  SEL_SECOND, 32'h0);
        settle();

        // capacity written as zero behaves as one: a single element fills the ring
        write_capacity('0);
        send_request(OP_PUSH, SEL_SECOND, 32'h5a5a_5a5a);
        send_request(OP_PUSH, SEL_FIRST,  32'h1111_1111);
        send_request(OP_PUSH, SEL_SECOND, 32'h2222_2222);
        send_request(OP_POP,  SEL_FIRST,  32'h0);
        send_request(OP_POP,  SEL_SECOND, 32'h0);
        send_request(OP_PUSH, SEL_FIRST,  32'ha5a5_a5a5);
        send_request(OP_POP,  SEL_FIRST,  32'h0);
        settle();

        // capacity two: downward stack wraps past slot 0, then refused push and pop
        write_capacity(CAP_W'(2));
        send_request(OP_PUSH, SEL_FIRST,  32'h0000_0001);
        send_request(OP_PUSH, SEL_FIRST,  32'hffff_fffe);
        send_request(OP_PUSH, SEL_FIRST,  32'h3333_3333);
        send_request(OP_POP,  SEL_SECOND, 32'h0);
        send_request(OP_POP,  SEL_FIRST,  32'h0);
        send_request(OP_POP,  SEL_FIRST,  32'h0);
        send_request(OP_POP,  SEL_FIRST,  32'h0);
        settle();

        // back pressure: result side holds off while requests keep coming back to back
        write_capacity(CAP_W'(MAX_ELEMENTS));
        no_gaps = 1'b1;
        rx_hold_cycles = 300;
        random_phase(64, 60);
        settle();
        no_gaps = 1'b0;

        // random phases, each under its own capacity setting
        while (requests_sent < 370)
        begin
            case ($urandom_range(0, 7))
                0:       cap = MAX_ELEMENTS;
                1:       cap = 0;
                2:       cap = 1;
                3:       cap = $urandom_range(1, MAX_ELEMENTS);
                default: cap = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 2))
                0:       push_pct = 75;
                1:       push_pct = 50;
                default: push_pct = 30;
            endcase
            write_capacity(CAP_W'(cap));
            no_gaps = ($urandom_range(0, 3) == 0);
            random_phase($urandom_range(20, 50), push_pct);
            settle();
        end
        no_gaps = 1'b0;

        $display("run covered %0d requests under %0d capacity writes, %0d results checked",
                 requests_sent, capacity_writes, results_checked);
        $display("refused pushes on a full ring: %0d, refused pops on an empty stack: %0d",
                 full_refusals, empty_refusals);
        if (mismatches == 0 && outstanding == 0)
            $display("[dual_stack_shared_ring_unit] OK");
        else
            $display("[dual_stack_shared_ring_unit] ERROR");
        $finish;
    end

endmodule
